>>> design/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
package stq_pkg;

  localparam int DL_W  = 48;
  localparam int ID_W  = 31;
  localparam int PAY_W = 32;

  localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  // command selector carried in in_tuser
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } stq_op_t;

  // result kind carried in out_tuser
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ID    = 3'd1;
  localparam logic [2:0] ST_BAD_IVAL  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_CMP,
    S_ADD_INS,
    S_CAN_CMP,
    S_CAN_DEL,
    S_TICK,
    S_REPLY
  } stq_state_t;

  typedef struct packed {
    logic [DL_W-1:0]  dl;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] pay;
  } stq_entry_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic            cmp_add;  // register deadline <= key
    logic            cmp_can;  // register id == key
    logic            ins;      // insert new entry, shift later ones up
    logic            del;      // drop first hit, shift later ones down
    logic            pop;      // drop the head, shift all down
    logic [DL_W-1:0] key_dl;
    logic [ID_W-1:0] key_id;
    logic [DL_W-1:0] now;
    stq_entry_t      new_ent;
  } stq_ctl_t;

endpackage

>>> design/stq_cell.sv
// One queue slot: holds an entry and shifts with its neighbors.
module stq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::stq_ctl_t  ctl,
  input  stq_pkg::stq_entry_t left_ent,
  input  logic               left_vld,
  input  logic               left_le,
  input  logic               left_hit,
  input  stq_pkg::stq_entry_t right_ent,
  input  logic               right_vld,
  output stq_pkg::stq_entry_t ent,
  output logic               vld,
  output logic               le,
  output logic               hit,
  output logic               expired
);

  stq_pkg::stq_entry_t ent_r, ent_nxt;
  logic vld_r, vld_nxt;
  logic le_r, match_r;

  assign hit     = left_hit | match_r;
  assign expired = vld_r & (ent_r.dl <= ctl.now);
  assign ent     = ent_r;
  assign vld     = vld_r;
  assign le      = le_r;

  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    if (ctl.ins && !le_r) begin
      // this entry moves up: new entry lands here if the left neighbor stays put, else the left entry shifts in
      ent_nxt = left_le ? ctl.new_ent : left_ent;
      vld_nxt = 1'b1;
      if (!left_le) vld_nxt = left_vld;
    end else if ((ctl.del && hit) || ctl.pop) begin
      ent_nxt = right_ent;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      vld_r   <= 1'b0;
      le_r    <= 1'b0;
      match_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (ctl.cmp_add) le_r <= vld_r & (ent_r.dl <= ctl.key_dl);
      if (ctl.cmp_can) match_r <= vld_r & (ent_r.id == ctl.key_id);
    end
  end

endmodule

>>> design/sorted_timer_queue.sv
// Top level: deadline-sorted timer queue built from a chain of shifting cells.
// Add: saturating add at accept, compare in every cell, then shift-insert with the reply beat.
// Cancel: id compare in every cell, then first-hit ripple and shift-down with the reply beat.
// Tick: time advances at accept, then one expiry beat per cycle from the head cell while the output is free.
// Rejected commands go to the reply state and send their reply beat from there. One command in flight at a time.
// Synchronous active-low reset empties the queue, zeroes time and sets the last id to 0.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // interval[31:0], payload[63:32], cancel_id[95:64]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status[2:0], timer_id[33:3], out_payload[65:34], zero pad
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  // last used id
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // ---------------- input decode ----------------
  stq_pkg::stq_op_t in_op;
  logic [31:0] in_interval, in_payload, in_cancel_id;
  logic        accept;

  assign in_op        = stq_pkg::stq_op_t'(in_tuser);
  assign in_interval  = in_tdata[31:0];
  assign in_payload   = in_tdata[63:32];
  assign in_cancel_id = in_tdata[95:64];

  // ---------------- state ----------------
  stq_pkg::stq_state_t state_r, state_nxt;
  logic [stq_pkg::DL_W-1:0]  now_r;
  logic [stq_pkg::DL_W-1:0]  key_dl_r;
  logic [stq_pkg::ID_W-1:0]  key_id_r;
  logic [stq_pkg::PAY_W-1:0] new_pay_r;
  logic [stq_pkg::ID_W-1:0]  last_id_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [1:0]                rep_kind_r;
  logic [2:0]                rep_status_r;

  // output stage
  logic                      out_vld_r;
  logic [1:0]                out_kind_r;
  logic [2:0]                out_status_r;
  logic [stq_pkg::ID_W-1:0]  out_id_r;
  logic [stq_pkg::PAY_W-1:0] out_pay_r;
  logic                      out_last_r;
  logic                      out_free;

  assign in_tready = (state_r == stq_pkg::S_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign out_free  = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_pay_r, out_id_r, out_status_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // command checks at accept
  logic                     ival_bad, cid_bad, q_full;
  logic [stq_pkg::DL_W:0]   dl_sum;
  logic [stq_pkg::DL_W-1:0] dl_sat;
  logic [stq_pkg::ID_W-1:0] next_id;

  assign ival_bad = in_interval[31] || (in_interval == 32'd0);
  assign cid_bad  = in_cancel_id[31] || (in_cancel_id == 32'd0);
  assign q_full   = (cnt_r == CNT_FULL);
  assign dl_sum   = {1'b0, now_r} + {18'd0, in_interval[30:0]};
  assign dl_sat   = dl_sum[stq_pkg::DL_W] ? stq_pkg::DL_MAX : dl_sum[stq_pkg::DL_W-1:0];
  // id wraps from the maximum back to 1; 0 also steps to 1
  assign next_id  = (last_id_r == stq_pkg::ID_MAX) ? stq_pkg::ID_W'(1)
                                                   : last_id_r + stq_pkg::ID_W'(1);

  // ---------------- cell chain ----------------
  stq_pkg::stq_ctl_t   ctl;
  stq_pkg::stq_entry_t c_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] c_vld, c_le, c_hit, c_exp;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      stq_pkg::stq_entry_t l_ent, r_ent;
      logic l_vld, l_le, l_hit, r_vld;
      if (g == 0) begin : g_head
        assign l_ent = '0;
        assign l_vld = 1'b1;
        assign l_le  = 1'b1;   // new entry may land in the head slot
        assign l_hit = 1'b0;
      end else begin : g_mid
        assign l_ent = c_ent[g-1];
        assign l_vld = c_vld[g-1];
        assign l_le  = c_le[g-1];
        assign l_hit = c_hit[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign r_ent = '0;
        assign r_vld = 1'b0;
      end else begin : g_body
        assign r_ent = c_ent[g+1];
        assign r_vld = c_vld[g+1];
      end
      stq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .left_ent  (l_ent),
        .left_vld  (l_vld),
        .left_le   (l_le),
        .left_hit  (l_hit),
        .right_ent (r_ent),
        .right_vld (r_vld),
        .ent       (c_ent[g]),
        .vld       (c_vld[g]),
        .le        (c_le[g]),
        .hit       (c_hit[g]),
        .expired   (c_exp[g])
      );
    end
  endgenerate

  logic found;
  assign found = c_hit[QUEUE_DEPTH-1];  // first-hit ripple reached the tail

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            stq_pkg::OP_ADD:    state_nxt = (ival_bad || q_full) ? stq_pkg::S_REPLY
                                                                 : stq_pkg::S_ADD_CMP;
            stq_pkg::OP_CANCEL: state_nxt = cid_bad ? stq_pkg::S_REPLY : stq_pkg::S_CAN_CMP;
            stq_pkg::OP_TICK:   state_nxt = stq_pkg::S_TICK;
            default:            state_nxt = stq_pkg::S_IDLE;
          endcase
        end
      end
      stq_pkg::S_ADD_CMP: state_nxt = stq_pkg::S_ADD_INS;
      stq_pkg::S_CAN_CMP: state_nxt = stq_pkg::S_CAN_DEL;
      stq_pkg::S_ADD_INS,
      stq_pkg::S_CAN_DEL,
      stq_pkg::S_REPLY: begin
        if (out_free) state_nxt = stq_pkg::S_IDLE;
      end
      stq_pkg::S_TICK: begin
        // leave once the head no longer expires after this beat
        if (out_free && !(c_exp[0] && c_exp[1])) state_nxt = stq_pkg::S_IDLE;
      end
      default: state_nxt = stq_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  logic                      ld_out, cnt_inc, cnt_dec, id_adv;
  logic [1:0]                o_kind;
  logic [2:0]                o_status;
  logic [stq_pkg::ID_W-1:0]  o_id;
  logic [stq_pkg::PAY_W-1:0] o_pay;
  logic                      o_last;

  always_comb begin
    ctl             = '0;
    ctl.key_dl      = key_dl_r;
    ctl.key_id      = key_id_r;
    ctl.now         = now_r;
    ctl.new_ent.dl  = key_dl_r;
    ctl.new_ent.id  = next_id;
    ctl.new_ent.pay = new_pay_r;
    ld_out   = 1'b0;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    id_adv   = 1'b0;
    o_kind   = rep_kind_r;
    o_status = rep_status_r;
    o_id     = '0;
    o_pay    = '0;
    o_last   = 1'b1;
    unique case (state_r)
      stq_pkg::S_ADD_CMP: ctl.cmp_add = 1'b1;
      stq_pkg::S_CAN_CMP: ctl.cmp_can = 1'b1;
      stq_pkg::S_ADD_INS: begin
        if (out_free) begin
          ctl.ins  = 1'b1;
          cnt_inc  = 1'b1;
          id_adv   = 1'b1;
          ld_out   = 1'b1;
          o_kind   = stq_pkg::KIND_ADD;
          o_status = stq_pkg::ST_OK;
          o_id     = next_id;
        end
      end
      stq_pkg::S_CAN_DEL: begin
        if (out_free) begin
          ctl.del  = 1'b1;
          cnt_dec  = found;
          ld_out   = 1'b1;
          o_kind   = stq_pkg::KIND_CANCEL;
          o_status = found ? stq_pkg::ST_OK : stq_pkg::ST_NOT_FOUND;
          o_id     = key_id_r;
        end
      end
      stq_pkg::S_TICK: begin
        if (out_free && c_exp[0]) begin
          ctl.pop  = 1'b1;
          cnt_dec  = 1'b1;
          ld_out   = 1'b1;
          o_kind   = stq_pkg::KIND_EXPIRE;
          o_status = stq_pkg::ST_OK;
          o_id     = c_ent[0].id;
          o_pay    = c_ent[0].pay;
          o_last   = !c_exp[1];
        end
      end
      stq_pkg::S_REPLY: begin
        ld_out = out_free;
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= stq_pkg::S_IDLE;
      now_r     <= '0;
      last_id_r <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) last_id_r <= cfg_wr_data;
      else if (id_adv) last_id_r <= next_id;

      if (cnt_inc) cnt_r <= cnt_r + CNT_W'(1);
      else if (cnt_dec) cnt_r <= cnt_r - CNT_W'(1);

      // time saturates at the top of the 48-bit range
      if (accept && in_op == stq_pkg::OP_TICK && now_r != stq_pkg::DL_MAX)
        now_r <= now_r + stq_pkg::DL_W'(1);

      if (ld_out) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_dl_r     <= dl_sat;
      new_pay_r    <= in_payload;
      key_id_r     <= in_cancel_id[30:0];
      rep_kind_r   <= (in_op == stq_pkg::OP_ADD) ? stq_pkg::KIND_ADD : stq_pkg::KIND_CANCEL;
      rep_status_r <= (in_op == stq_pkg::OP_CANCEL) ? stq_pkg::ST_BAD_ID :
                      ival_bad ? stq_pkg::ST_BAD_IVAL : stq_pkg::ST_FULL;
    end
    if (ld_out) begin
      out_kind_r   <= o_kind;
      out_status_r <= o_status;
      out_id_r     <= o_id;
      out_pay_r    <= o_pay;
      out_last_r   <= o_last;
    end
  end

endmodule
